@@ rtl/cphr_pkg.sv @@
`timescale 1ns / 1ps

package cphr_pkg;

    // largest drive value
    localparam logic [7:0] MAX_POWER = 8'd255;

    typedef logic [2:0] reg_idx_t;

    localparam reg_idx_t REG_P_GAIN       = 3'd0;
    localparam reg_idx_t REG_I_GAIN       = 3'd1;
    localparam reg_idx_t REG_D_GAIN       = 3'd2;
    localparam reg_idx_t REG_SETPOINT_ONE = 3'd3;
    localparam reg_idx_t REG_SETPOINT_TWO = 3'd4;
    localparam reg_idx_t REG_SUM_LIMIT    = 3'd5;
    localparam reg_idx_t REG_P_TERM_LIMIT = 3'd6;
    localparam reg_idx_t REG_D_TERM_LIMIT = 3'd7;

    typedef struct packed {
        logic        [15:0] p_gain;
        logic        [15:0] i_gain;
        logic        [15:0] d_gain;
        logic signed [15:0] setpoint_one;
        logic signed [15:0] setpoint_two;
        logic        [23:0] sum_limit;
        logic        [30:0] p_term_limit;
        logic        [30:0] d_term_limit;
    } cfg_t;

    // error stage result
    typedef struct packed {
        logic signed [16:0] err;
        logic signed [24:0] sum;
        logic signed [16:0] temp_diff;
    } front_t;

    // term stage result
    typedef struct packed {
        logic signed [31:0] prop;
        logic signed [41:0] integ;
        logic signed [31:0] deriv;
    } terms_t;

    // saturate a gain product to +/- lim
    function automatic logic signed [31:0] clamp_term(input logic signed [33:0] v,
                                                       input logic [30:0] lim);
        logic signed [33:0] hi;
        logic signed [33:0] lo;
        logic signed [31:0] r;
        hi = signed'({3'b000, lim});
        lo = -hi;
        if (v > hi)
        begin
            r = hi[31:0];
        end
        else if (v < lo)
        begin
            r = lo[31:0];
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

@@ rtl/clamped_pid_heater_regulator_unit.sv @@
`timescale 1ns / 1ps

// channel   | direction | signals                        | contents
// s_axis    | in        | tvalid tready tdata[15:0] tuser[1:0] | temperature sample
// m_axis    | out       | tvalid tready tdata[119:0]     | drive value and pid terms
// cfg       | in        | cfg_we cfg_index[2:0] cfg_data[30:0] | gain, setpoint, limit regs
//
// one item per cycle sustained while the output is not stalled; each item passes three
// register stages: error/integral stage, gain multiply stage, sum and clamp stage
// whose register is the output.
// integral sum, previous sample and setpoint choice update at the accept edge.
// a stalled output only holds the stages that are full behind it.
// rst_n clears config registers, controller state and all valid flags.

module clamped_pid_heater_regulator_unit
    import cphr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,

    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [15:0]  s_axis_tdata,   // [15:0] measured_temp
    input  logic [1:0]   s_axis_tuser,   // [0] use_second_setpoint, [1] clear_integral

    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [7:0] heater_power, [39:8] prop_term, [81:40] integ_term,
    // [113:82] deriv_term, [119:114] zero
    output logic [119:0] m_axis_tdata,

    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [30:0]  cfg_data
);

    cfg_t       cfg;
    logic       front_valid;
    logic       front_ready;
    front_t     front_data;
    logic       terms_valid;
    logic       terms_ready;
    terms_t     terms_data;
    logic [7:0] heater_power;
    terms_t     out_terms;

    cphr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cphr_front u_front (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg                 (cfg),
        .in_valid            (s_axis_tvalid),
        .in_ready            (s_axis_tready),
        .measured_temp       (signed'(s_axis_tdata)),
        .use_second_setpoint (s_axis_tuser[0]),
        .clear_integral      (s_axis_tuser[1]),
        .out_valid           (front_valid),
        .out_ready           (front_ready),
        .out_data            (front_data)
    );

    cphr_terms u_terms (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_data   (front_data),
        .out_valid (terms_valid),
        .out_ready (terms_ready),
        .out_data  (terms_data)
    );

    cphr_out u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (terms_valid),
        .in_ready     (terms_ready),
        .in_data      (terms_data),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .heater_power (heater_power),
        .out_terms    (out_terms)
    );

    assign m_axis_tdata = {6'd0, out_terms.deriv, out_terms.integ, out_terms.prop,
                           heater_power};

    // drive value never exceeds its ceiling
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[7:0] <= MAX_POWER))
        else $error("heater power above ceiling");

    // with the output empty the whole pipe can move, so input must be open
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked while output empty");

    // an accepted item always lands in the first stage
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> front_valid)
        else $error("accepted item lost at first stage");

    // a full first stage that cannot move keeps the input closed
    assert property (@(posedge clk) disable iff (!rst_n)
        (front_valid && !front_ready) |-> !s_axis_tready)
        else $error("input open while first stage stalled");

endmodule

@@ rtl/cphr_cfg.sv @@
`timescale 1ns / 1ps

module cphr_cfg
    import cphr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  reg_idx_t    cfg_index,
    input  logic [30:0] cfg_data,
    output cfg_t        cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_P_GAIN:       cfg_reg.p_gain       <= cfg_data[15:0];
                REG_I_GAIN:       cfg_reg.i_gain       <= cfg_data[15:0];
                REG_D_GAIN:       cfg_reg.d_gain       <= cfg_data[15:0];
                REG_SETPOINT_ONE: cfg_reg.setpoint_one <= signed'(cfg_data[15:0]);
                REG_SETPOINT_TWO: cfg_reg.setpoint_two <= signed'(cfg_data[15:0]);
                REG_SUM_LIMIT:    cfg_reg.sum_limit    <= cfg_data[23:0];
                REG_P_TERM_LIMIT: cfg_reg.p_term_limit <= cfg_data[30:0];
                REG_D_TERM_LIMIT: cfg_reg.d_term_limit <= cfg_data[30:0];
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/cphr_front.sv @@
`timescale 1ns / 1ps

module cphr_front
    import cphr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] measured_temp,
    input  logic               use_second_setpoint,
    input  logic               clear_integral,
    output logic               out_valid,
    input  logic               out_ready,
    output front_t             out_data
);

    logic               sel_reg;
    logic signed [24:0] sum_reg;
    logic signed [15:0] prev_reg;
    logic               valid_reg;
    front_t             data_reg;

    logic               accept;
    logic               switch_sel;
    logic signed [24:0] sum_base;
    logic signed [15:0] prev_base;
    logic signed [15:0] setpoint;
    logic signed [16:0] err;
    logic signed [16:0] temp_diff;
    logic signed [25:0] raw_sum;
    logic signed [25:0] lim_hi;
    logic signed [25:0] lim_lo;
    logic signed [24:0] sum_next;

    assign in_ready = !valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        switch_sel = use_second_setpoint != sel_reg;
        sum_base   = (switch_sel || clear_integral) ? '0 : sum_reg;
        prev_base  = switch_sel ? '0 : prev_reg;
        setpoint   = use_second_setpoint ? cfg.setpoint_two : cfg.setpoint_one;
        err        = signed'({setpoint[15], setpoint})
                   - signed'({measured_temp[15], measured_temp});
        temp_diff  = signed'({prev_base[15], prev_base})
                   - signed'({measured_temp[15], measured_temp});
        raw_sum    = signed'({sum_base[24], sum_base}) + signed'({{9{err[16]}}, err});
        lim_hi     = signed'({2'b00, cfg.sum_limit});
        lim_lo     = -lim_hi;
        if (raw_sum > lim_hi)
        begin
            sum_next = lim_hi[24:0];
        end
        else if (raw_sum < lim_lo)
        begin
            sum_next = lim_lo[24:0];
        end
        else
        begin
            sum_next = raw_sum[24:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg   <= 1'b0;
            sum_reg   <= '0;
            prev_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                valid_reg <= in_valid;
            end
            if (accept)
            begin
                sel_reg  <= use_second_setpoint;
                sum_reg  <= sum_next;
                prev_reg <= measured_temp;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg.err       <= err;
            data_reg.sum       <= sum_next;
            data_reg.temp_diff <= temp_diff;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

@@ rtl/cphr_terms.sv @@
`timescale 1ns / 1ps

module cphr_terms
    import cphr_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  cfg_t   cfg,
    input  logic   in_valid,
    output logic   in_ready,
    input  front_t in_data,
    output logic   out_valid,
    input  logic   out_ready,
    output terms_t out_data
);

    logic               valid_reg;
    terms_t             data_reg;

    logic               accept;
    logic signed [16:0] p_gain_s;
    logic signed [16:0] i_gain_s;
    logic signed [16:0] d_gain_s;
    logic signed [16:0] err;
    logic signed [24:0] sum;
    logic signed [16:0] temp_diff;
    logic signed [33:0] p_prod;
    logic signed [41:0] i_prod;
    logic signed [33:0] d_prod;

    assign in_ready = !valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        p_gain_s  = signed'({1'b0, cfg.p_gain});
        i_gain_s  = signed'({1'b0, cfg.i_gain});
        d_gain_s  = signed'({1'b0, cfg.d_gain});
        err       = in_data.err;
        sum       = in_data.sum;
        temp_diff = in_data.temp_diff;
        p_prod    = p_gain_s * err;
        i_prod    = i_gain_s * sum;
        d_prod    = d_gain_s * temp_diff;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg.prop  <= clamp_term(p_prod, cfg.p_term_limit);
            data_reg.integ <= i_prod;
            data_reg.deriv <= clamp_term(d_prod, cfg.d_term_limit);
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

@@ rtl/cphr_out.sv @@
`timescale 1ns / 1ps

module cphr_out
    import cphr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  terms_t      in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  heater_power,
    output terms_t      out_terms
);

    logic               valid_reg;
    logic [7:0]         power_reg;
    terms_t             terms_reg;

    logic               accept;
    logic signed [43:0] total;
    logic        [30:0] shifted;
    logic        [7:0]  power_next;

    assign in_ready = !valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        total   = signed'({{12{in_data.prop[31]}}, in_data.prop})
                + signed'({{2{in_data.integ[41]}}, in_data.integ})
                + signed'({{12{in_data.deriv[31]}}, in_data.deriv});
        shifted = total[42:12];
        // negative total drives nothing, large total saturates
        if (total[43])
        begin
            power_next = 8'd0;
        end
        else if (shifted > {23'd0, MAX_POWER})
        begin
            power_next = MAX_POWER;
        end
        else
        begin
            power_next = shifted[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            power_reg <= power_next;
            terms_reg <= in_data;
        end
    end

    assign out_valid    = valid_reg;
    assign heater_power = power_reg;
    assign out_terms    = terms_reg;

endmodule
